// ===== rtl/conv3x3_line_buffer_top_defines.svh =====
// Assertion macros for the 3x3 line buffer convolution block.
`ifndef CONV3X3_LINE_BUFFER_TOP_DEFINES_SVH
`define CONV3X3_LINE_BUFFER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define C3LB_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Same-cycle implication.
`define C3LB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define C3LB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/c3lb_pkg.sv =====
// Types and constants of the 3x3 line buffer convolution block.
package c3lb_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 4096;

   localparam int COL_W = $clog2(MAX_WIDTH);       // column index
   localparam int WID_W = $clog2(MAX_WIDTH + 1);   // clamped width value
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);  // row count, includes filler row

   localparam int PIX_W          = 16;
   localparam int COEF_W         = 8;
   localparam int KROW_W         = 24;
   localparam int FRAME_WIDTH_W  = 10;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 24;

   localparam logic [FRAME_WIDTH_W-1:0]  WIDTH_RESET  = FRAME_WIDTH_W'(440);
   localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_RESET = FRAME_HEIGHT_W'(330);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_TOP    = 3'd0,
      CSR_KERNEL_MIDDLE = 3'd1,
      CSR_KERNEL_BOTTOM = 3'd2,
      CSR_FRAME_WIDTH   = 3'd3,
      CSR_FRAME_HEIGHT  = 3'd4
   } csr_index_type;

   typedef logic signed [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic emit_one;   // item releases at least one result
      logic emit_two;   // item releases a second, right-border result
      logic frame_end;  // second result closes the frame
   } emit_type;

   typedef struct packed {
      logic [PIX_W-1:0] result;
      logic             last_of_run;
      logic             frame_end;
   } result_type;

   function automatic logic signed [COEF_W-1:0] coef_at(logic [KROW_W-1:0] krow, int j);
      return $signed(krow[COEF_W*j +: COEF_W]);
   endfunction

endpackage

// ===== rtl/conv3x3_line_buffer_top.sv =====
// 3x3 zero-padded correlation over a raster pixel stream with two line stores.
// A released result passes the stage 1, window and product registers, then the result queue, before rsp.
// Throughput: one item per cycle; the 4-entry result queue stalls req when it holds
// more than two results, since one item can release two.
// Line stores are 512-entry memories, one write and one registered read per cycle.
// Synchronous active-high reset clears counters, config, valids and queue; no clearing pass.
`include "conv3x3_line_buffer_top_defines.svh"

module conv3x3_line_buffer_top
   import c3lb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [15:0] pixel
   input  logic                  req_tuser,   // [0] filler
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,   // [15:0] result
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,   // [0] frame_end
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration
   logic [KROW_W-1:0]         kernel_ff [3];
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [WID_W-1:0] width_eff;
   logic [ROW_W-1:0] height_eff;
   logic             last_col;
   logic             fill_row;
   logic             adv;
   logic             accept;
   emit_type         emit_in;
   pixel_type        pixel_in;

   // stage 1: accepted item and line store reads
   pixel_type        line_above_mem   [MAX_WIDTH];
   pixel_type        line_current_mem [MAX_WIDTH];
   pixel_type        above_rd_ff;
   pixel_type        current_rd_ff;
   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_clear_ff;
   logic             s1_above_ok_ff;
   logic             s1_current_ok_ff;
   pixel_type        s1_pixel_ff;
   emit_type         s1_emit_ff;
   pixel_type        above_val;
   pixel_type        current_val;

   // stage 2: window
   pixel_type win_ff [3][3];
   pixel_type win_in [3][3];
   logic      s2_valid_ff;
   emit_type  s2_emit_ff;

   // stage 3: products, low 16 bits suffice for the wrapped sum
   logic [PIX_W-1:0] prod0_ff [3][3];
   logic [PIX_W-1:0] prod1_ff [3][2];
   logic [PIX_W-1:0] prod0_in [3][3];
   logic [PIX_W-1:0] prod1_in [3][2];
   logic             s3_valid_ff;
   emit_type         s3_emit_ff;
   logic [PIX_W-1:0] sum0;
   logic [PIX_W-1:0] sum1;

   // result queue
   result_type            fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic                  push0;
   logic                  push1;
   logic                  pop;
   result_type            entry0;
   result_type            entry1;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff[0]    <= '0;
         kernel_ff[1]    <= '0;
         kernel_ff[2]    <= '0;
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_KERNEL_TOP:    kernel_ff[0]    <= csr_data[KROW_W-1:0];
            CSR_KERNEL_MIDDLE: kernel_ff[1]    <= csr_data[KROW_W-1:0];
            CSR_KERNEL_BOTTOM: kernel_ff[2]    <= csr_data[KROW_W-1:0];
            CSR_FRAME_WIDTH:   frame_width_ff  <= csr_data[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff <= csr_data[FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff < FRAME_WIDTH_W'(2)) begin
         width_eff = WID_W'(2);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WID_W'(MAX_WIDTH);
      end else begin
         width_eff = WID_W'(frame_width_ff);
      end
      if (frame_height_ff < FRAME_HEIGHT_W'(2)) begin
         height_eff = ROW_W'(2);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         height_eff = ROW_W'(frame_height_ff);
      end
   end

   // ---------------------------------------------------------------- stage 0
   // whole pipeline moves together; room for two results keeps the queue safe
   assign adv        = fifo_cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   assign last_col = WID_W'(col_ff) >= (width_eff - WID_W'(1));
   assign fill_row = row_ff >= height_eff;
   assign pixel_in = (req_tuser || fill_row) ? pixel_type'(0) : $signed(req_tdata);

   always_comb begin
      emit_in.emit_one  = (row_ff != '0) && (col_ff != '0);
      emit_in.emit_two  = emit_in.emit_one && last_col;
      emit_in.frame_end = fill_row;
      if (last_col) begin
         col_in = '0;
         row_in = fill_row ? '0 : ROW_W'(row_ff + 1'b1);
      end else begin
         col_in = COL_W'(col_ff + 1'b1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff        <= col_ff;
         s1_clear_ff      <= col_ff == '0;
         s1_above_ok_ff   <= row_ff >= ROW_W'(2);
         s1_current_ok_ff <= row_ff != '0;
         s1_pixel_ff      <= pixel_in;
         s1_emit_ff       <= emit_in;
      end
   end

   // the next item always reads a different column than the one written here
   always_ff @(posedge clock) begin
      if (adv) begin
         above_rd_ff   <= line_above_mem[col_ff];
         current_rd_ff <= line_current_mem[col_ff];
      end
      if (adv && s1_valid_ff) begin
         line_above_mem[s1_col_ff]   <= current_val;
         line_current_mem[s1_col_ff] <= s1_pixel_ff;
      end
   end

   assign above_val   = s1_above_ok_ff   ? above_rd_ff   : pixel_type'(0);
   assign current_val = s1_current_ok_ff ? current_rd_ff : pixel_type'(0);

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = s1_clear_ff ? pixel_type'(0) : win_ff[i][1];
         win_in[i][1] = s1_clear_ff ? pixel_type'(0) : win_ff[i][2];
      end
      win_in[0][2] = above_val;
      win_in[1][2] = current_val;
      win_in[2][2] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_emit_ff <= s1_emit_ff;
         if (s1_valid_ff) begin
            win_ff <= win_in;
         end
      end
   end

   // ---------------------------------------------------------------- stage 3
   always_comb begin
      logic signed [PIX_W+COEF_W-1:0] full;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            full           = win_ff[i][j] * coef_at(kernel_ff[i], j);
            prod0_in[i][j] = full[PIX_W-1:0];
         end
         // window shifted one column left, zero enters on the right
         for (int j = 0; j < 2; j++) begin
            full           = win_ff[i][j+1] * coef_at(kernel_ff[i], j);
            prod1_in[i][j] = full[PIX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_emit_ff <= s2_emit_ff;
         prod0_ff   <= prod0_in;
         prod1_ff   <= prod1_in;
      end
   end

   always_comb begin
      sum0 = '0;
      sum1 = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sum0 = sum0 + prod0_ff[i][j];
         end
         for (int j = 0; j < 2; j++) begin
            sum1 = sum1 + prod1_ff[i][j];
         end
      end
   end

   // ---------------------------------------------------------------- result queue
   assign push0 = adv && s3_valid_ff && s3_emit_ff.emit_one;
   assign push1 = adv && s3_valid_ff && s3_emit_ff.emit_two;
   assign pop   = rsp_tvalid && rsp_tready;

   always_comb begin
      entry0.result      = sum0;
      entry0.last_of_run = !s3_emit_ff.emit_two;
      entry0.frame_end   = 1'b0;
      entry1.result      = sum1;
      entry1.last_of_run = 1'b1;
      entry1.frame_end   = s3_emit_ff.frame_end;
      wr_ptr_in   = FIFO_PTR_W'(wr_ptr_ff + FIFO_PTR_W'(push0) + FIFO_PTR_W'(push1));
      rd_ptr_in   = FIFO_PTR_W'(rd_ptr_ff + FIFO_PTR_W'(pop));
      fifo_cnt_in = FIFO_CNT_W'(fifo_cnt_ff + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1)
                                - FIFO_CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         fifo_ff[wr_ptr_ff] <= entry0;
      end
      if (push1) begin
         fifo_ff[FIFO_PTR_W'(wr_ptr_ff + 1'b1)] <= entry1;
      end
   end

   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign rsp_tdata  = fifo_ff[rd_ptr_ff].result;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last_of_run;
   assign rsp_tuser  = fifo_ff[rd_ptr_ff].frame_end;

   // ---------------------------------------------------------------- checks
   `C3LB_ASSERT_ALWAYS(a_fifo_bound, fifo_cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH), "queue overflow")
   `C3LB_ASSERT_IMPLIES(a_frame_end_last, rsp_tvalid && rsp_tuser, rsp_tlast, "frame end not last")
   `C3LB_ASSERT_IMPLIES(a_two_needs_one, s3_valid_ff && s3_emit_ff.emit_two, s3_emit_ff.emit_one, "second result without first")
   `C3LB_ASSERT_NEXT(a_stall_holds_pos, !accept, $stable(col_ff) && $stable(row_ff), "position moved without item")

endmodule

// ===== tb/sv/conv3x3_line_buffer_top_test.sv =====
// Self-checking stream test of the 3x3 zero-padded convolution block.
module conv3x3_line_buffer_top_test;
   import c3lb_pkg::*;

   localparam int SETTLE_CYCLES = 8;     // pipeline latency plus margin before a register write
   localparam int STALL_LIMIT   = 4000;  // cycles without any handshake before giving up
   localparam int RANDOM_ITEMS  = 700;
   localparam int LONG_HOLD     = 300;
   localparam int PRINT_CAP     = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;  // indexes past the register map

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata  = '0;  // [15:0] pixel
   logic                  req_tuser  = 1'b0;  // [0] filler
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;  // [15:0] result
   logic                  rsp_tlast;
   logic                  rsp_tuser;  // [0] frame_end
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_KERNEL_TOP;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   conv3x3_line_buffer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---- shadow of the block: registers, line stores, window, raster position
   logic [KROW_W-1:0]         kernel_rows [3];
   logic [FRAME_WIDTH_W-1:0]  width_reg;
   logic [FRAME_HEIGHT_W-1:0] height_reg;
   pixel_type                 above_line   [MAX_WIDTH];
   pixel_type                 current_line [MAX_WIDTH];
   pixel_type                 taps [3][3];
   logic [COL_W-1:0]          next_col;
   logic [ROW_W-1:0]          next_row;
   result_type                expected_results [$];

   int  items_sent    = 0;
   int  random_items  = 0;
   int  results_seen  = 0;
   int  frames_done   = 0;
   int  reg_writes    = 0;
   int  mismatches    = 0;
   int  hold_request  = 0;
   int  long_holds    = 0;
   bit  source_gaps   = 1'b1;
   bit  sink_jitter   = 1'b1;

   function automatic void clear_shadow();
      for (int i = 0; i < 3; i++) kernel_rows[i] = '0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) taps[i][j] = '0;
      next_col = '0;
      next_row = '0;
   endfunction

   function automatic int eff_width();
      if (width_reg < 2) return 2;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
   endfunction

   function automatic int eff_height();
      if (height_reg < 2) return 2;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(height_reg);
   endfunction

   // window shifted left by 'shift' columns, zeros enter on the right
   function automatic logic [PIX_W-1:0] window_sum(input int shift);
      int acc;
      logic signed [COEF_W-1:0] k;
      acc = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            k = kernel_rows[i][COEF_W*j +: COEF_W];
            if (j + shift < 3) acc += int'(taps[i][j+shift]) * int'(k);
         end
      return acc[PIX_W-1:0];
   endfunction

   function automatic void predict_item(input logic [PIX_W-1:0] pix, input logic fil);
      int w, h, col;
      bit last_col, fill_row;
      pixel_type v, a, b;
      result_type r;
      w = eff_width();
      h = eff_height();
      col = int'(next_col);
      last_col = (col >= w - 1);
      fill_row = (next_row >= h);
      v = (fil || fill_row) ? pixel_type'(0) : pixel_type'(pix);
      a = (next_row >= 2) ? above_line[col] : pixel_type'(0);
      b = (next_row >= 1) ? current_line[col] : pixel_type'(0);
      if (col == 0)
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) taps[i][j] = '0;
      for (int i = 0; i < 3; i++) begin
         taps[i][0] = taps[i][1];
         taps[i][1] = taps[i][2];
      end
      taps[0][2] = a;
      taps[1][2] = b;
      taps[2][2] = v;
      above_line[col]   = b;
      current_line[col] = v;
      if (next_row >= 1 && col >= 1) begin
         r.result      = window_sum(0);
         r.last_of_run = !last_col;
         r.frame_end   = 1'b0;
         expected_results.push_back(r);
         // right border: second result with the window run off the edge
         if (last_col) begin
            r.result      = window_sum(1);
            r.last_of_run = 1'b1;
            r.frame_end   = fill_row;
            expected_results.push_back(r);
         end
      end
      if (last_col) begin
         next_col = '0;
         if (fill_row) begin
            next_row = '0;
            frames_done++;
         end else begin
            next_row = next_row + 1'b1;
         end
      end else begin
         next_col = COL_W'(col + 1);
      end
   endfunction

   // ---- random picks
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h8000;
      if (r < 20) return 16'h7FFF;
      if (r < 30) return PIX_W'($signed($urandom_range(0, 8)) - 4);
      return PIX_W'($urandom);
   endfunction

   function automatic logic [KROW_W-1:0] pick_kernel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 24'h808080;
      if (r < 20) return 24'h7F7F7F;
      if (r < 25) return '0;
      return KROW_W'($urandom);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_width_data();
      int r;
      logic [CSR_DATA_W-1:0] d;
      r = $urandom_range(0, 99);
      if (r < 12) d = CSR_DATA_W'($urandom_range(0, 1));
      else if (r < 20) d = CSR_DATA_W'($urandom_range(11, 48));
      else d = CSR_DATA_W'($urandom_range(2, 10));
      // bits above the register width must be dropped
      if ($urandom_range(0, 3) == 0)
         d[CSR_DATA_W-1:FRAME_WIDTH_W] = (CSR_DATA_W-FRAME_WIDTH_W)'($urandom);
      return d;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_height_data();
      logic [CSR_DATA_W-1:0] d;
      if ($urandom_range(0, 99) < 15) d = CSR_DATA_W'($urandom_range(0, 1));
      else d = CSR_DATA_W'($urandom_range(2, 6));
      if ($urandom_range(0, 3) == 0)
         d[CSR_DATA_W-1:FRAME_HEIGHT_W] = (CSR_DATA_W-FRAME_HEIGHT_W)'($urandom);
      return d;
   endfunction

   // ---- drivers
   task automatic send_item(input logic [PIX_W-1:0] pix, input logic fil);
      int gap;
      gap = source_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= fil;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_item(pix, fil);
   endtask

   // item shaped by the raster position: real pixels in real rows, filler in the filler row, noise_pct percent flipped
   task automatic send_next(input int noise_pct);
      logic fil;
      if (next_row >= eff_height()) fil = ($urandom_range(0, 99) >= noise_pct);
      else fil = ($urandom_range(0, 99) < noise_pct);
      send_item(pick_pixel(), fil);
   endtask

   task automatic stream_items(input int count, input int noise_pct);
      repeat (count) send_next(noise_pct);
   endtask

   task automatic stream_to_frame_end(input int noise_pct);
      do send_next(noise_pct); while (next_col != 0 || next_row != 0);
   endtask

   // csr_valid stays up; the caller drops it after its group of writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
      case (idx)
         CSR_KERNEL_TOP:    kernel_rows[0] = data;
         CSR_KERNEL_MIDDLE: kernel_rows[1] = data;
         CSR_KERNEL_BOTTOM: kernel_rows[2] = data;
         CSR_FRAME_WIDTH:   width_reg  = data[FRAME_WIDTH_W-1:0];
         CSR_FRAME_HEIGHT:  height_reg = data[FRAME_HEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   // sender idle, all results back, pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_frame(input logic [CSR_DATA_W-1:0] wd, input logic [CSR_DATA_W-1:0] hd,
                                  input logic [KROW_W-1:0] k0, input logic [KROW_W-1:0] k1,
                                  input logic [KROW_W-1:0] k2);
      settle();
      write_reg(CSR_KERNEL_TOP, k0);
      write_reg(CSR_KERNEL_MIDDLE, k1);
      write_reg(CSR_KERNEL_BOTTOM, k2);
      write_reg(CSR_FRAME_WIDTH, wd);
      write_reg(CSR_FRAME_HEIGHT, hd);
      csr_valid <= 1'b0;
   endtask

   // ---- result side
   task automatic report_mismatch(input string note);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("MISMATCH result %0d: %s", results_seen, note);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected item, data %h", rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata !== want.result)
               report_mismatch($sformatf("result expected %h got %h", want.result, rsp_tdata));
            if (rsp_tlast !== want.last_of_run)
               report_mismatch($sformatf("tlast expected %b got %b", want.last_of_run, rsp_tlast));
            if (rsp_tuser !== want.frame_end)
               report_mismatch($sformatf("frame end expected %b got %b", want.frame_end, rsp_tuser));
         end
      end
   end

   initial begin : result_sink
      int span;
      @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            rsp_tready <= 1'b0;
            span = hold_request;
            hold_request = 0;
            long_holds++;
         end else if (sink_jitter && $urandom_range(0, 99) < 30) begin
            rsp_tready <= 1'b0;
            span = 1 + pick_gap();
         end else begin
            rsp_tready <= 1'b1;
            span = $urandom_range(1, 8);
         end
         repeat (span) @(posedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---- tests
   // kernel left at its reset value, so every result is zero; height below 2 clamps to two
   task automatic test_reset_values();
      write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(5));
      write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(1));
      csr_valid <= 1'b0;
      stream_to_frame_end(0);
   endtask

   // extreme pixels and coefficients, filler in a real row, real pixel in the filler row
   task automatic test_corner_items();
      configure_frame(CSR_DATA_W'(3), CSR_DATA_W'(2), 24'h807FFF, 24'h01807F, 24'h808080);
      send_item(16'h7FFF, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'h7FFF, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'h1234, 1'b1);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h5555, 1'b1);
      send_item(16'hAAAA, 1'b1);
      send_item(16'h7FFF, 1'b0);
      settle();
      // writes past the register map must change nothing
      for (int s = CSR_SPARE_FIRST; s < 2 ** CSR_IDX_W; s++)
         write_reg(CSR_IDX_W'(s), CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      // width and height of zero and one clamp to two; full-scale sums wrap
      configure_frame(CSR_DATA_W'(0), CSR_DATA_W'(1), 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
      for (int n = 0; n < 6; n++) send_item(16'h7FFF, n >= 4);
      configure_frame(CSR_DATA_W'(1), CSR_DATA_W'(0), 24'h808080, 24'h808080, 24'h808080);
      stream_to_frame_end(0);
   endtask

   // width past the maximum clamps to 512; the frame is left open at the end of the run
   task automatic test_widest_frame();
      configure_frame(CSR_DATA_W'(1023), CSR_DATA_W'(0), pick_kernel(), pick_kernel(),
                      pick_kernel());
      stream_items(eff_width() + 4, 0);
   endtask

   // height past the maximum, then cut short by a height write in mid-frame
   task automatic test_tallest_frame();
      configure_frame(CSR_DATA_W'(2), CSR_DATA_W'(8191), pick_kernel(), pick_kernel(),
                      pick_kernel());
      stream_items(12, 0);
      settle();
      write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(0));
      csr_valid <= 1'b0;
      stream_to_frame_end(0);
   endtask

   // output held off while input keeps coming, then a pause until everything drains
   task automatic test_output_stall();
      configure_frame(CSR_DATA_W'(16), CSR_DATA_W'(6), pick_kernel(), pick_kernel(),
                      pick_kernel());
      source_gaps = 1'b0;
      sink_jitter = 1'b0;
      stream_items(32, 0);
      hold_request = LONG_HOLD;
      stream_items(48, 0);
      settle();
      source_gaps = 1'b1;
      sink_jitter = 1'b1;
      stream_to_frame_end(0);
   endtask

   task automatic test_random_frames();
      int noise;
      while (random_items < RANDOM_ITEMS) begin
         source_gaps = ($urandom_range(0, 3) != 0);
         sink_jitter = ($urandom_range(0, 3) != 0);
         noise = ($urandom_range(0, 4) == 0) ? 25 : 0;
         configure_frame(pick_width_data(), pick_height_data(), pick_kernel(), pick_kernel(),
                         pick_kernel());
         do begin
            // mid-frame changes of kernel or height; width only moves between frames
            if ((next_col != 0 || next_row != 0) && $urandom_range(0, 99) < 3) begin
               settle();
               if ($urandom_range(0, 1) == 1)
                  write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'($urandom_range(0, 8)));
               else
                  write_reg(CSR_IDX_W'($urandom_range(CSR_KERNEL_TOP, CSR_KERNEL_BOTTOM)),
                            pick_kernel());
               csr_valid <= 1'b0;
            end
            send_next(noise);
            random_items++;
         end while (next_col != 0 || next_row != 0);
      end
   endtask

   initial begin
      clear_shadow();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_corner_items();
      test_output_stall();
      test_tallest_frame();
      test_random_frames();
      test_widest_frame();
      settle();
      $display("run: %0d items in %0d frames, %0d results compared, %0d register writes",
               items_sent, frames_done, results_seen, reg_writes);
      $display("run: small and clamped widths and heights, filler noise, %0d long output holds",
               long_holds);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/c3lb_pkg.sv
rtl/conv3x3_line_buffer_top.sv
tb/sv/conv3x3_line_buffer_top_test.sv
